// File: hw/rtl/bpcc_pkg.sv
package bpcc_pkg;

  localparam int RADIX_W = 32;
  localparam int COUNT_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 32'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 32'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;

  // control from the sequencer to the shared divider
  typedef struct packed {
    logic load;   // capture a new dividend pair
    logic start;  // begin one base-p digit pass
  } bpcc_div_ctrl_t;

endpackage

// File: hw/rtl/bpcc_div_unit.sv
module bpcc_div_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bpcc_pkg::bpcc_div_ctrl_t           ctrl,
  input  logic [DATA_WIDTH-1:0]              load_m,
  input  logic [DATA_WIDTH-1:0]              load_d,
  input  logic [bpcc_pkg::RADIX_W-1:0]       radix,
  input  logic [$clog2(DATA_WIDTH)-1:0]      start_idx,
  output logic                               done,
  output logic [bpcc_pkg::RADIX_W-1:0]       rem_m,
  output logic [bpcc_pkg::RADIX_W-1:0]       rem_d,
  output logic [DATA_WIDTH-1:0]              quo_m
);
  import bpcc_pkg::*;

  localparam int IdxW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] val_m_r, val_d_r;
  logic [DATA_WIDTH-1:0] quo_m_r, quo_d_r;
  logic [DATA_WIDTH-1:0] quo_m_nxt, quo_d_nxt;
  logic [RADIX_W-1:0]    rem_m_r, rem_d_r;
  logic [RADIX_W-1:0]    rem_m_nxt, rem_d_nxt;
  logic [IdxW-1:0]       idx_r;
  logic                  run_r;
  logic                  done_r;
  logic [RADIX_W:0]      trial_m, trial_d;
  logic                  qbit_m, qbit_d;

  // one restoring step per lane: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial_m   = {rem_m_r, val_m_r[idx_r]};
    trial_d   = {rem_d_r, val_d_r[idx_r]};
    qbit_m    = (trial_m >= {1'b0, radix});
    qbit_d    = (trial_d >= {1'b0, radix});
    rem_m_nxt = qbit_m ? RADIX_W'(trial_m - {1'b0, radix}) : trial_m[RADIX_W-1:0];
    rem_d_nxt = qbit_d ? RADIX_W'(trial_d - {1'b0, radix}) : trial_d[RADIX_W-1:0];
    quo_m_nxt = {quo_m_r[DATA_WIDTH-2:0], qbit_m};
    quo_d_nxt = {quo_d_r[DATA_WIDTH-2:0], qbit_d};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        run_r <= 1'b1;
      end else if (run_r && (idx_r == '0)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      val_m_r <= load_m;
      val_d_r <= load_d;
    end else if (run_r && (idx_r == '0)) begin
      // quotients become the dividends of the next digit
      val_m_r <= quo_m_nxt;
      val_d_r <= quo_d_nxt;
    end
    if (ctrl.start) begin
      quo_m_r <= '0;
      quo_d_r <= '0;
      rem_m_r <= '0;
      rem_d_r <= '0;
      idx_r   <= start_idx;
    end else if (run_r) begin
      quo_m_r <= quo_m_nxt;
      quo_d_r <= quo_d_nxt;
      rem_m_r <= rem_m_nxt;
      rem_d_r <= rem_d_nxt;
      idx_r   <= idx_r - 1'b1;
    end
  end

  assign done  = done_r;
  assign rem_m = rem_m_r;
  assign rem_d = rem_d_r;
  assign quo_m = val_m_r;

endmodule

// File: hw/rtl/binomial_prime_carry_count_core.sv
// channel  direction  handshake            payload
// in_      in         in_valid / in_stall   in_top_value, in_lower_value
// out_     out        out_valid / out_stall out_carry_count, out_divisible, out_invalid
// cfg_     in         cfg_valid / cfg_ready cfg_data (radix)
//
// one request at a time; a shared two-lane restoring divider peels one base-p
// digit of m and d per pass, one dividend bit per cycle
// pass i (from 0) shifts in dividend bits DATA_WIDTH-1-i down to 0; a request
// runs one pass per base-p digit of m, and no pass when m is 0 or the request
// is invalid
// rst_n is synchronous; it returns the radix to 2 and drops all valids
// a stalled result sits in the output register while the next request runs;
// that request then waits in done until the register frees up
// a pending config write holds off new requests
module binomial_prime_carry_count_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [DATA_WIDTH-1:0]           in_top_value,
  input  logic [DATA_WIDTH-1:0]           in_lower_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bpcc_pkg::COUNT_W-1:0]    out_carry_count,
  output logic                            out_divisible,
  output logic                            out_invalid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bpcc_pkg::RADIX_W-1:0]    cfg_data
);
  import bpcc_pkg::*;

  localparam int IdxW = $clog2(DATA_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [RADIX_W-1:0]  radix_r;
  logic [IdxW-1:0]     idx_r, idx_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic                borrow_r, borrow_nxt;
  logic                inv_r, inv_nxt;
  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_cnt_r;
  logic                out_div_r, out_inv_r;

  bpcc_div_ctrl_t      div_ctrl;
  logic [IdxW-1:0]     start_idx;
  logic                div_done;
  logic [RADIX_W-1:0]  rem_m, rem_d;
  logic [DATA_WIDTH-1:0] quo_m;

  logic in_acc, bad_req, digit_borrow, out_free;

  bpcc_div_unit #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .load_m    (in_top_value),
    .load_d    (in_lower_value),
    .radix     (radix_r),
    .start_idx (start_idx),
    .done      (div_done),
    .rem_m     (rem_m),
    .rem_d     (rem_d),
    .quo_m     (quo_m)
  );

  // a radix write and a request never land on the same edge
  assign in_stall  = (state_r != S_IDLE) | cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign bad_req   = (radix_r < RADIX_MIN) | (in_lower_value > in_top_value);

  // borrow out of this digit of m - d
  assign digit_borrow = {1'b0, rem_m} < ({1'b0, rem_d} + {{RADIX_W{1'b0}}, borrow_r});
  assign cnt_inc      = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    borrow_nxt     = borrow_r;
    inv_nxt        = inv_r;
    div_ctrl       = '0;
    start_idx      = idx_r - 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          div_ctrl.load = 1'b1;
          cnt_nxt       = '0;
          borrow_nxt    = 1'b0;
          inv_nxt       = bad_req;
          if (bad_req || (in_top_value == '0)) begin
            state_nxt = S_DONE;
          end else begin
            div_ctrl.start = 1'b1;
            start_idx      = IdxW'(DATA_WIDTH - 1);
            idx_nxt        = IdxW'(DATA_WIDTH - 1);
            state_nxt      = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (div_done) begin
          cnt_nxt    = digit_borrow ? cnt_inc : cnt_r;
          borrow_nxt = digit_borrow;
          if (quo_m == '0) begin
            state_nxt = S_DONE;
          end else begin
            // quotient is at least one bit shorter than the last dividend
            div_ctrl.start = 1'b1;
            idx_nxt        = idx_r - 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radix_r     <= RADIX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        radix_r <= cfg_data;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    borrow_r <= borrow_nxt;
    inv_r    <= inv_nxt;
    if ((state_r == S_DONE) && out_free) begin
      out_cnt_r <= cnt_r;
      out_div_r <= |cnt_r;
      out_inv_r <= inv_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_carry_count = out_cnt_r;
  assign out_divisible   = out_div_r;
  assign out_invalid     = out_inv_r;

endmodule

// File: hw/rtl/bpcc_chk.sv
module bpcc_chk #(
  parameter int DATA_WIDTH = 32
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [bpcc_pkg::COUNT_W-1:0]    out_carry_count,
  input logic                            out_divisible,
  input logic                            out_invalid,
  input logic                            cfg_ready
);
  import bpcc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_carry_count)
      && $stable(out_divisible) && $stable(out_invalid))
    else $error("result changed while stalled");

  // invalid request reports a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> (out_carry_count == '0) && !out_divisible)
    else $error("invalid result with nonzero count");

  // divisible flag follows the count
  a_div_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_divisible == (out_carry_count != '0)))
    else $error("divisible flag disagrees with count");

  // an accepted request keeps the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("block not busy after accepting a request");

  // carries cannot exceed the digit count
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_carry_count) <= DATA_WIDTH))
    else $error("carry count out of range");

endmodule

bind binomial_prime_carry_count_core bpcc_chk #(.DATA_WIDTH(DATA_WIDTH)) u_bpcc_chk (.*);

// File: test/binomial_prime_carry_count_checker.sv
`timescale 1ns / 100ps

module binomial_prime_carry_count_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [DATA_WIDTH-1:0]        in_top_value,
  input  logic [DATA_WIDTH-1:0]        in_lower_value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [bpcc_pkg::COUNT_W-1:0] out_carry_count,
  input  logic                         out_divisible,
  input  logic                         out_invalid,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [bpcc_pkg::RADIX_W-1:0] cfg_data,
  output int                           error_count,
  output int                           open_count
);
  import bpcc_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               divisible;
    logic               invalid;
  } carry_result_t;

  logic [RADIX_W-1:0] radix_copy;
  carry_result_t      predicted_carries[$];

  // add d and m - d digit by digit in the given base, counting carries
  function automatic carry_result_t kummer_carry_result(
    input logic [RADIX_W-1:0]    base,
    input logic [DATA_WIDTH-1:0] m,
    input logic [DATA_WIDTH-1:0] d
  );
    carry_result_t res;
    logic [63:0]   a;
    logic [63:0]   b;
    logic [63:0]   bw;
    logic [63:0]   s;
    logic          c;
    int unsigned   n;
    res = '0;
    if (base < RADIX_MIN || d > m) begin
      res.invalid = 1'b1;
      return res;
    end
    a  = 64'(d);
    b  = 64'(m - d);
    bw = 64'(base);
    c  = 1'b0;
    n  = 0;
    while (a != 0 || b != 0 || c) begin
      s = (a % bw) + (b % bw) + 64'(c);
      if (s >= bw) begin
        n++;
        c = 1'b1;
      end else begin
        c = 1'b0;
      end
      a = a / bw;
      b = b / bw;
    end
    if (n > COUNT_MAX) n = COUNT_MAX;
    res.count     = n[COUNT_W-1:0];
    res.divisible = (n != 0);
    return res;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    carry_result_t want;
    carry_result_t got;
    if (!rst_n) begin
      radix_copy  = RADIX_RESET;
      error_count = 0;
      predicted_carries.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.count     = out_carry_count;
        got.divisible = out_divisible;
        got.invalid   = out_invalid;
        if (predicted_carries.size() == 0) begin
          error_count++;
          $display("%0t: result with no request pending, expected none, actual %0d/%0d/%0d",
                   $time, got.count, got.divisible, got.invalid);
        end else begin
          want = predicted_carries.pop_front();
          compare_field("carry_count", want.count, got.count);
          compare_field("divisible", want.divisible, got.divisible);
          compare_field("invalid", want.invalid, got.invalid);
        end
      end
      if (in_valid && !in_stall)
        predicted_carries.insert(predicted_carries.size(),
                                 kummer_carry_result(radix_copy, in_top_value,
                                                     in_lower_value));
      if (cfg_valid && cfg_ready) radix_copy = cfg_data;
    end
    open_count = predicted_carries.size();
  end

endmodule

// File: test/tb_binomial_prime_carry_count_core.sv
`timescale 1ns / 100ps

module tb_binomial_prime_carry_count_core;
  import bpcc_pkg::*;

  localparam int DW          = 32;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 600;
  localparam int PHASE_ITEMS = 70;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [DW-1:0]       in_top_value   = '0;
  logic [DW-1:0]       in_lower_value = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [COUNT_W-1:0]  out_carry_count;
  logic                out_divisible;
  logic                out_invalid;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [RADIX_W-1:0]  cfg_data       = '0;

  int error_count;
  int open_count;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_span = 0;

  binomial_prime_carry_count_core #(
    .DATA_WIDTH(DW)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_top_value   (in_top_value),
    .in_lower_value (in_lower_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_carry_count(out_carry_count),
    .out_divisible  (out_divisible),
    .out_invalid    (out_invalid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  binomial_prime_carry_count_checker #(
    .DATA_WIDTH(DW)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_top_value   (in_top_value),
    .in_lower_value (in_lower_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_carry_count(out_carry_count),
    .out_divisible  (out_divisible),
    .out_invalid    (out_invalid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .open_count     (open_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stall pattern: free, coin flip, heavy, periodic
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(1, 60);
      stall_mode = $urandom_range(0, 3);
    end
    stall_span--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 1);
      2:       out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= stall_span[2];
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_binomial_prime_carry_count_core: errors");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic push_request(input logic [DW-1:0] m, input logic [DW-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_top_value   <= m;
    in_lower_value <= d;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // block must be idle before the radix changes
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    in_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    burst_left = 0;
  endtask

  // lower value whose base-r digits never exceed those of m: no carries (any value up to m when r is below 2)
  function automatic logic [DW-1:0] digitwise_below(input logic [DW-1:0] m,
                                                    input logic [RADIX_W-1:0] r);
    logic [63:0] mm;
    logic [63:0] pw;
    logic [63:0] acc;
    logic [63:0] dig;
    if (r < RADIX_MIN) return DW'($urandom_range(m, 0));
    mm  = 64'(m);
    pw  = 64'd1;
    acc = 64'd0;
    while (mm != 0) begin
      dig = mm % 64'(r);
      acc = acc + (64'($urandom) % (dig + 1)) * pw;
      mm  = mm / 64'(r);
      pw  = pw * 64'(r);
    end
    return acc[DW-1:0];
  endfunction

  task automatic random_request(input logic [RADIX_W-1:0] r);
    logic [DW-1:0] m;
    logic [DW-1:0] d;
    int            sel;
    case ($urandom_range(0, 2))
      0:       m = $urandom;
      1:       m = $urandom_range(0, 4095);
      default: m = $urandom >> $urandom_range(0, 31);
    endcase
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      // lower above top, or plain noise when m is already the maximum
      d = (m == '1) ? $urandom : $urandom_range(32'hFFFF_FFFF, m + 1);
    end else if (sel < 4) begin
      d = digitwise_below(m, r);
    end else if (sel == 4) begin
      d = ($urandom_range(0, 1) == 1) ? m : '0;
    end else begin
      d = $urandom_range(m, 0);
    end
    push_request(m, d);
  endtask

  initial begin
    logic [RADIX_W-1:0] radix_list [13];
    logic [RADIX_W-1:0] r;
    radix_list = '{32'd2, 32'hFFFF_FFFF, 32'd3, 32'd0, 32'd10, 32'd5, 32'd1, 32'd7,
                   32'd65537, 32'hFFFF_FFFB, 32'd0, 32'd0, 32'd2};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset radix of two
    push_request(32'd0, 32'd0);
    push_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(32'hFFFF_FFFF, 32'd0);
    push_request(32'd0, 32'hFFFF_FFFF);
    push_request(32'h8000_0000, 32'd1);
    push_request(32'hFFFF_FFFF, 32'h8000_0000);
    push_request(32'd6, 32'd3);
    push_request(32'd5, 32'd6);
    set_radix(32'd3);
    push_request(32'd9, 32'd3);
    push_request(32'hFFFF_FFFF, 32'h5555_5555);
    set_radix(32'd0);
    push_request(32'd5, 32'd2);
    set_radix(32'd1);
    push_request(32'd5, 32'd2);
    set_radix(32'hFFFF_FFFF);
    push_request(32'hFFFF_FFFF, 32'd1);
    push_request(32'hFFFF_FFFE, 32'h7FFF_FFFF);
    set_radix(32'd10);
    push_request(32'd100, 32'd55);
    push_request(32'd99, 32'd45);

    foreach (radix_list[i]) begin
      r = radix_list[i];
      if (i == 10) r = $urandom;
      if (i == 11) r = $urandom_range(2, 64);
      set_radix(r);
      repeat (PHASE_ITEMS) random_request(r);
    end

    in_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (error_count == 0 && open_count == 0) begin
      $display("tb_binomial_prime_carry_count_core: clean");
    end else begin
      $display("tb_binomial_prime_carry_count_core: errors");
    end
    $finish;
  end

endmodule
